// ===== hw/rtl/dsort_pkg.sv =====
// Package for the depth sort block: field widths, register indexes and the
// word and cell types shared by the interface, the cells and the top level.
// No dependencies.
package dsort_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DIST_W     = 34;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_ATOMS_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

  // Input word: one atom
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]          atom_index;
    logic                      last;
  } atom_t;

  // Output word: one sorted result
  typedef struct packed {
    logic [IDX_W-1:0]  sorted_index;
    logic [DIST_W-1:0] distance_sq;
    logic              final_flag;
    logic              overflow_flag;
  } result_t;

  // Contents of one sort cell
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] key;
    logic [IDX_W-1:0]  tag;
  } entry_t;

  // Key broadcast to the chain by the distance pipeline
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [DIST_W-1:0] key;
    logic [IDX_W-1:0]  tag;
  } insert_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [DIST_W-1:0] key;
    logic [IDX_W-1:0]  tag;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

endpackage

// ===== hw/rtl/dsort_stream_if.sv =====
// Valid/ready stream interface used for the atom and result channels.
// The payload type is set at instantiation; no package dependency.
interface dsort_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/depth_sort_by_camera_distance.sv =====
// Top level of the depth sort block: camera registers, distance pipeline,
// chain of sort cells and the load/emit control.
// Depends on dsort_pkg, dsort_stream_if, dsort_dist and dsort_cell.
//
// Usage: write camera_x/y/z (indexes 0..2) through cfg_we_i while idle.
// Send atoms on atom_i, one word per cycle while ready is high; each passes
// the difference, square and sum pipeline stages, then drops into place in
// the chain, where every cell compares the new key with its own in parallel.
// A word with last set closes the set: atom_i.ready falls right after it
// and stays low until the final result of that set is taken.
// Once the last word is in the chain, result_o presents the held atoms
// in ascending squared distance (load order on ties), one word per cycle
// while result_o.ready is high; the chain shifts toward the output on each
// taken word, so a stalled receiver simply holds the current word.
// final_flag marks the last word; overflow_flag is set on every word of a
// set that lost atoms to a full chain of MAX_ATOMS cells.
// Reset clears the camera registers, the chain and the control state.
module depth_sort_by_camera_distance #(
  parameter int unsigned MAX_ATOMS  = dsort_pkg::MAX_ATOMS_DEF,
  parameter int unsigned COORD_BITS = dsort_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dsort_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dsort_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  dsort_stream_if.sink                        atom_i,
  dsort_stream_if.source                      result_o
);
  import dsort_pkg::*;

  logic [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
  state_e             state_d, state_q;
  logic               pend_d, pend_q;
  logic               dropped_d, dropped_q;
  logic               in_take, pop, full, is_final;
  insert_t            ins;
  cell_ctrl_t         ctrl;
  entry_t             cell_e [MAX_ATOMS];
  logic               cell_gt [MAX_ATOMS];

  // Camera registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAMERA_X: cam_x_q <= COORD_W'(cfg_data_i);
        REG_CAMERA_Y: cam_y_q <= COORD_W'(cfg_data_i);
        REG_CAMERA_Z: cam_z_q <= COORD_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Accept atoms until a last word is taken; resume once its set has drained
  assign atom_i.ready = !pend_q;
  assign in_take      = atom_i.valid && atom_i.ready;

  dsort_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_take),
    .atom_i   (atom_i.data),
    .cam_x_i  (cam_x_q),
    .cam_y_i  (cam_y_q),
    .cam_z_i  (cam_z_q),
    .ins_o    (ins)
  );

  // Chain control
  assign full        = cell_e[MAX_ATOMS-1].valid;
  assign ctrl.insert = ins.valid && !full;
  assign ctrl.pop    = pop;
  assign ctrl.key    = ins.key;
  assign ctrl.tag    = ins.tag;

  // Cell chain: left neighbor feeds on insert, right neighbor on pop
  for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_gt;

    if (i == 0) begin : g_head
      assign left_e  = '{valid: 1'b1, key: '0, tag: '0};
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_e  = cell_e[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == MAX_ATOMS - 1) begin : g_tail
      assign right_e = '{valid: 1'b0, key: '0, tag: '0};
    end else begin : g_inner
      assign right_e = cell_e[i+1];
    end

    dsort_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (cell_e[i]),
      .gt_o      (cell_gt[i])
    );
  end

  // Output word straight from the head cell
  assign is_final                    = !cell_e[1].valid;
  assign result_o.valid              = (state_q == ST_EMIT) && cell_e[0].valid;
  assign result_o.data.sorted_index  = cell_e[0].tag;
  assign result_o.data.distance_sq   = cell_e[0].key;
  assign result_o.data.final_flag    = is_final;
  assign result_o.data.overflow_flag = dropped_q;
  assign pop                         = result_o.valid && result_o.ready;

  // Next state
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    dropped_d = dropped_q;
    if (in_take && atom_i.data.last) begin
      pend_d = 1'b1;
    end
    case (state_q)
      ST_LOAD: begin
        if (ins.valid && full) begin
          dropped_d = 1'b1;
        end
        if (ins.valid && ins.last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pop && is_final) begin
          state_d   = ST_LOAD;
          pend_d    = 1'b0;
          dropped_d = 1'b0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      pend_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      dropped_q <= dropped_d;
    end
  end

`ifndef SYNTHESIS
  a_no_insert_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !ins.valid)
    else $error("insert reached the chain while draining");

  a_last_starts_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins.valid && ins.last) |=> (state_q == ST_EMIT) && result_o.valid)
    else $error("last word did not start the drain");

  a_drain_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !is_final) |=> result_o.valid)
    else $error("chain ran dry before the final word");

  a_final_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && is_final) |=> !cell_e[0].valid && !pend_q && !dropped_q)
    else $error("chain not empty after the final word");
`endif

endmodule

// ===== hw/rtl/dsort_dist.sv =====
// Three-stage squared-distance pipeline: difference, square, sum.
// Depends on dsort_pkg.
module dsort_dist #(
  parameter int unsigned COORD_BITS = dsort_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  dsort_pkg::atom_t                       atom_i,
  input  logic [dsort_pkg::COORD_W-1:0]          cam_x_i,
  input  logic [dsort_pkg::COORD_W-1:0]          cam_y_i,
  input  logic [dsort_pkg::COORD_W-1:0]          cam_z_i,
  output dsort_pkg::insert_t                     ins_o
);
  import dsort_pkg::*;

  localparam int unsigned EXT_W  = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned SUM_W  = SQ_W + 2;
  localparam int unsigned FULL_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  // Keep the low COORD_BITS bits of a word as a two's complement value
  function automatic logic signed [COORD_BITS-1:0] trim(input logic [COORD_W-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[COORD_BITS-1:0];
  endfunction

  logic signed [DIFF_W-1:0] dx_d, dy_d, dz_d;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [DIFF_W-1:0]        mx, my, mz;
  logic [SQ_W-1:0]          sx_d, sy_d, sz_d;
  logic [SQ_W-1:0]          sx_q, sy_q, sz_q;
  logic [FULL_W-1:0]        sum_full;
  logic [IDX_W-1:0]         tag1_q, tag2_q;
  logic                     last1_q, last2_q;
  logic                     v1_q, v2_q;
  insert_t                  ins_q;

  // Stage 1: exact per-axis differences
  assign dx_d = DIFF_W'(trim(atom_i.pos_x)) - DIFF_W'(trim(cam_x_i));
  assign dy_d = DIFF_W'(trim(atom_i.pos_y)) - DIFF_W'(trim(cam_y_i));
  assign dz_d = DIFF_W'(trim(atom_i.pos_z)) - DIFF_W'(trim(cam_z_i));

  // Stage 2: magnitudes and squares
  assign mx   = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
  assign my   = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
  assign mz   = dz_q[DIFF_W-1] ? DIFF_W'(-dz_q) : DIFF_W'(dz_q);
  assign sx_d = SQ_W'(mx) * SQ_W'(mx);
  assign sy_d = SQ_W'(my) * SQ_W'(my);
  assign sz_d = SQ_W'(mz) * SQ_W'(mz);

  // Stage 3: sum, wrapped to the key width
  assign sum_full = FULL_W'(sx_q) + FULL_W'(sy_q) + FULL_W'(sz_q);

  // Advance valid bits and the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      ins_q <= '0;
    end else begin
      v1_q       <= accept_i;
      v2_q       <= v1_q;
      ins_q.valid <= v2_q;
      ins_q.key  <= sum_full[DIST_W-1:0];
      ins_q.tag  <= tag2_q;
      ins_q.last <= last2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    dz_q       <= dz_d;
    tag1_q     <= atom_i.atom_index;
    last1_q    <= atom_i.last;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sz_q       <= sz_d;
    tag2_q     <= tag1_q;
    last2_q    <= last1_q;
  end

  assign ins_o = ins_q;

endmodule

// ===== hw/rtl/dsort_cell.sv =====
// One cell of the insertion-sort chain: holds one (distance, index) entry,
// takes the new key or its left neighbor on insert, its right neighbor on pop.
// Depends on dsort_pkg.
module dsort_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsort_pkg::cell_ctrl_t ctrl_i,
  input  dsort_pkg::entry_t     left_i,
  input  logic                  left_gt_i,
  input  dsort_pkg::entry_t     right_i,
  output dsort_pkg::entry_t     entry_o,
  output logic                  gt_o
);
  import dsort_pkg::*;

  entry_t ent_d, ent_q;
  logic   gt;

  // Held key lies strictly beyond the new one; equal keys stay in front
  assign gt = ent_q.valid && (ent_q.key > ctrl_i.key);

  // Pick the next contents
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.pop) begin
      ent_d = right_i;
    end else if (ctrl_i.insert && (gt || !ent_q.valid)) begin
      if (left_gt_i) begin
        ent_d = left_i;
      end else if (left_i.valid) begin
        ent_d.valid = 1'b1;
        ent_d.key   = ctrl_i.key;
        ent_d.tag   = ctrl_i.tag;
      end
    end
  end

  // Hold the entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign entry_o = ent_q;
  assign gt_o    = gt;

endmodule

// ===== tb/sv/depth_sort_by_camera_distance_tb.sv =====
// Testbench for depth_sort_by_camera_distance: streams sets of atoms under several camera
// settings and checks each sorted word against a scoreboard of expected results.
// Depends on dsort_pkg, dsort_stream_if and the depth_sort_by_camera_distance RTL.
module depth_sort_by_camera_distance_tb;
  import dsort_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ATOMS = 200;

  // Expected sort order of the atoms taken so far, and checking of the emitted words
  class depth_ledger;
    logic signed [COORD_W-1:0] cam [3];
    logic [DIST_W-1:0] held_keys [$];
    logic [IDX_W-1:0]  held_tags [$];
    bit                lost_atoms;
    result_t           sorted_due [$];
    int                errors;

    function new();
      cam = '{default: '0};
      lost_atoms = 1'b0;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void set_camera(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_CAMERA_X: cam[0] = v;
        REG_CAMERA_Y: cam[1] = v;
        REG_CAMERA_Z: cam[2] = v;
        default: ;
      endcase
    endfunction

    function logic [DIST_W-1:0] camera_dist_sq(atom_t a);
      longint dx, dy, dz;
      logic [DIST_W-1:0] s;
      dx = longint'(a.pos_x) - longint'(cam[0]);
      dy = longint'(a.pos_y) - longint'(cam[1]);
      dz = longint'(a.pos_z) - longint'(cam[2]);
      s = DIST_W'(dx * dx + dy * dy + dz * dz);
      return s;
    endfunction

    // Insert behind equal keys, drop when full, release the run on last
    function void take_atom(atom_t a);
      logic [DIST_W-1:0] k;
      int pos;
      result_t r;
      k = camera_dist_sq(a);
      if (held_keys.size() < MAX_ATOMS_DEF) begin
        pos = held_keys.size();
        while (pos > 0 && held_keys[pos-1] > k) pos--;
        held_keys.insert(pos, k);
        held_tags.insert(pos, a.atom_index);
      end else begin
        lost_atoms = 1'b1;
      end
      if (a.last) begin
        foreach (held_keys[i]) begin
          r.sorted_index  = held_tags[i];
          r.distance_sq   = held_keys[i];
          r.final_flag    = (i == held_keys.size() - 1);
          r.overflow_flag = lost_atoms;
          sorted_due.push_back(r);
        end
        held_keys.delete();
        held_tags.delete();
        lost_atoms = 1'b0;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (sorted_due.size() == 0) begin
        report($sformatf("word with nothing due: index %0d dist %0d",
                         got.sorted_index, got.distance_sq));
        return;
      end
      want = sorted_due.pop_front();
      if (got.sorted_index !== want.sorted_index)
        report($sformatf("sorted_index got %0d want %0d", got.sorted_index, want.sorted_index));
      if (got.distance_sq !== want.distance_sq)
        report($sformatf("distance_sq got %0d want %0d (index %0d)",
                         got.distance_sq, want.distance_sq, want.sorted_index));
      if (got.final_flag !== want.final_flag)
        report($sformatf("final_flag got %0b want %0b (index %0d)",
                         got.final_flag, want.final_flag, want.sorted_index));
      if (got.overflow_flag !== want.overflow_flag)
        report($sformatf("overflow_flag got %0b want %0b (index %0d)",
                         got.overflow_flag, want.overflow_flag, want.sorted_index));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dsort_stream_if #(.payload_t(atom_t))   atom_if ();
  dsort_stream_if #(.payload_t(result_t)) result_if ();

  depth_ledger board = new();
  int cycle_count = 0;
  int random_items = 0;

  depth_sort_by_camera_distance uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .atom_i     (atom_if),
    .result_o   (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Receive side: check each taken word, stall at random with calm stretches
  initial begin
    int calm_left;
    int stall_left;
    calm_left = 0;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready)
        board.check_result(result_if.data);
      if (calm_left > 0) begin
        calm_left--;
        result_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        case ($urandom_range(0, 19))
          0:       calm_left = $urandom_range(20, 60);
          1, 2, 3: stall_left = idle_len();
          default: ;
        endcase
      end
    end
  end

  function automatic atom_t make_atom(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                      logic signed [COORD_W-1:0] z, logic [IDX_W-1:0] idx,
                                      logic last);
    atom_t a;
    a.pos_x = x;
    a.pos_y = y;
    a.pos_z = z;
    a.atom_index = idx;
    a.last = last;
    return a;
  endfunction

  // Full range, close to the camera (ties), or an extreme
  function automatic logic signed [COORD_W-1:0] rand_coord(logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] t;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        t = COORD_W'($urandom);
        return t;
      end
      3, 4: begin
        t = COORD_W'($urandom_range(0, 6));
        return c + t - 16'sd3;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  task automatic send_atom(atom_t a, bit calm);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      atom_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    atom_if.valid <= 1'b1;
    atom_if.data  <= a;
    do @(posedge clk_i); while (!atom_if.ready);
    board.take_atom(a);
  endtask

  task automatic send_set(int n);
    bit calm;
    atom_t a;
    calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      a = make_atom(rand_coord(board.cam[0]), rand_coord(board.cam[1]),
                    rand_coord(board.cam[2]), IDX_W'($urandom_range(0, 63)), i == n - 1);
      send_atom(a, calm);
      random_items++;
    end
  endtask

  // Hold valid low and wait for every due word, then let the pipeline settle
  task automatic drain_results();
    atom_if.valid <= 1'b0;
    while (board.sorted_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    board.set_camera(idx, v);
  endtask

  // Write all three camera registers, then poke the unused index
  task automatic program_camera(logic [CFG_DATA_W-1:0] x, logic [CFG_DATA_W-1:0] y,
                                logic [CFG_DATA_W-1:0] z);
    write_reg(REG_CAMERA_X, x);
    write_reg(REG_CAMERA_Y, y);
    write_reg(REG_CAMERA_Z, z);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  initial begin
    int phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_CAMERA_X;
    cfg_data_i    = '0;
    atom_if.valid = 1'b0;
    atom_if.data  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Camera at reset origin: extremes, origin, and four-way tie in load order
    send_atom(make_atom(16'sh8000, 16'sh8000, 16'sh8000, 6'd63, 1'b0), 1'b0);
    send_atom(make_atom(16'sh7fff, 16'sh7fff, 16'sh7fff, 6'd0, 1'b0), 1'b0);
    send_atom(make_atom(16'sd0, 16'sd0, 16'sd0, 6'd21, 1'b0), 1'b0);
    send_atom(make_atom(16'sd1, 16'sd0, 16'sd0, 6'd5, 1'b0), 1'b0);
    send_atom(make_atom(16'sd0, -16'sd1, 16'sd0, 6'd42, 1'b0), 1'b0);
    send_atom(make_atom(16'sd0, 16'sd0, 16'sd1, 6'd5, 1'b0), 1'b0);
    send_atom(make_atom(-16'sd1, 16'sd0, 16'sd0, 6'd33, 1'b1), 1'b0);
    // Single-atom set
    send_atom(make_atom(16'sd12345, -16'sd4321, 16'sd7, 6'd17, 1'b1), 1'b0);
    drain_results();

    // Camera at the negative corner: largest distance and zero distance
    program_camera(16'h8000, 16'h8000, 16'h8000);
    send_atom(make_atom(16'sh7fff, 16'sh7fff, 16'sh7fff, 6'd62, 1'b0), 1'b0);
    send_atom(make_atom(16'sh8000, 16'sh8000, 16'sh8000, 6'd1, 1'b1), 1'b0);
    drain_results();

    // Mixed-sign camera
    program_camera(16'h7fff, 16'h8000, 16'h0000);
    send_atom(make_atom(16'sh8000, 16'sh7fff, 16'sd0, 6'd9, 1'b0), 1'b0);
    send_atom(make_atom(16'sh7fff, 16'sh8000, 16'sd0, 6'd50, 1'b0), 1'b0);
    send_atom(make_atom(16'sd0, 16'sd0, 16'sd0, 6'd3, 1'b1), 1'b0);

    // Random sets across camera settings; a full set and an overfilled one early on
    phase = 0;
    while (random_items < RANDOM_ATOMS) begin
      phase++;
      drain_results();
      case (phase % 5)
        0:       program_camera(16'h0000, 16'h0000, 16'h0000);
        1:       program_camera(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                CFG_DATA_W'($urandom));
        2:       program_camera(16'h7fff, 16'h7fff, 16'h7fff);
        3:       program_camera(16'h8000, 16'h8000, 16'h8000);
        default: program_camera(extreme_value(), extreme_value(), extreme_value());
      endcase
      if (phase == 1) send_set(MAX_ATOMS_DEF);
      if (phase == 2) send_set(MAX_ATOMS_DEF + $urandom_range(1, 5));
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) == 0) send_set($urandom_range(9, MAX_ATOMS_DEF));
        else send_set($urandom_range(1, 8));
      end
    end
    drain_results();

    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== depth_sort_by_camera_distance.f =====
hw/rtl/dsort_pkg.sv
hw/rtl/dsort_stream_if.sv
hw/rtl/dsort_dist.sv
hw/rtl/dsort_cell.sv
hw/rtl/depth_sort_by_camera_distance.sv
tb/sv/depth_sort_by_camera_distance_tb.sv
